// ----- rtl/core/window_mean_std_min_max_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the windowed statistics block
// Clocked on i_clk, off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WINDOW_MEAN_STD_MIN_MAX_ASSERT_SVH
`define WINDOW_MEAN_STD_MIN_MAX_ASSERT_SVH

// Condition implies consequence in the same cycle
`define WMSM_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error("wmsm assertion failed");

// Condition implies consequence in the next cycle
`define WMSM_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error("wmsm assertion failed");

`endif

// ----- rtl/core/wmsm_pkg.sv -----
// ---------------------------------------------------------------------------
// wmsm_pkg
// Shared constants and types of the windowed statistics block.
// ---------------------------------------------------------------------------
package wmsm_pkg;

    // Sample and result field widths
    localparam int SAMPLE_W   = 16;
    localparam int STD_W      = 15;
    localparam int OUT_DATA_W = 64;

    // Default window length
    localparam int WINDOW_DEF = 16;

    // Largest std value that the result field holds
    localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};

    // Status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- rtl/core/wmsm_div.sv -----
// ---------------------------------------------------------------------------
// wmsm_div
// Bit-serial restoring divider by the window length: one quotient bit per
// cycle, a narrow remainder and compare-subtract.
// ---------------------------------------------------------------------------
module wmsm_div import wmsm_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF,
    parameter int DW     = SAMPLE_W + $clog2(WINDOW_DEF)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_dividend,
    output t_div_stat                  o_stat,
    output logic [DW-1:0]              o_quot,
    output logic [$clog2(WINDOW)-1:0]  o_rem
);

    localparam int NB   = $clog2(WINDOW);
    localparam int CNTW = $clog2(DW);
    localparam logic [NB:0] DIVISOR = (NB+1)'(WINDOW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_dq;
    logic [NB-1:0]   r_rem;

    logic [NB:0]     n_trial;
    logic            n_ge;
    logic [NB:0]     n_diff;

    // One restoring step: bring down the next dividend bit
    assign n_trial = {r_rem, r_dq[DW-1]};
    assign n_ge    = (n_trial >= DIVISOR);
    assign n_diff  = n_trial - DIVISOR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // one-cycle pulse with the last step
            r_done <= r_busy && !i_start && (r_cnt == CNTW'(DW-1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dq   <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                // quotient bits shift in behind the dividend bits
                r_dq  <= {r_dq[DW-2:0], n_ge};
                r_rem <= n_ge ? n_diff[NB-1:0] : n_trial[NB-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(DW-1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_dq;
    assign o_rem       = r_rem;

endmodule

// ----- rtl/core/window_mean_std_min_max.sv -----
// ---------------------------------------------------------------------------
// window_mean_std_min_max
// Mean, population std, maximum and minimum over non-overlapping windows.
// ---------------------------------------------------------------------------
// Samples (signed Q8.8) are taken one at a time and gathered into windows
// of WINDOW samples; after the last sample of a window one result transfer
// carries floor(S1/N), floor(isqrt(N*S2 - S1*S1)/N), the maximum and the
// minimum, and the window starts over. Each sample is squared by the
// shift-add multiplier that feeds the sum of squares, and no new sample
// is taken until that square is done. After the last sample of a window
// the serial divider (mean and std), the shift-add multiplier (S1*S1 and
// N*S2) and the one-bit-a-cycle square root work out the result. A
// finished result waits in the output register while the next window is
// gathered; a window end waits only if the previous result has not been
// taken yet.
// ---------------------------------------------------------------------------
`include "window_mean_std_min_max_assert.svh"

module window_mean_std_min_max import wmsm_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample in: tdata[15:0] sample
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,
    // result out: tdata[15:0] window_mean, [30:16] window_std,
    // [46:31] window_max, [62:47] window_min, [63] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int L   = $clog2(WINDOW);
    localparam int SW  = SAMPLE_W + L;        // signed sum
    localparam int MW  = SAMPLE_W + L;        // sum magnitude, root
    localparam int S2W = 2*SAMPLE_W - 1 + L;  // sum of squares
    localparam int PW  = 2*SAMPLE_W - 1 + 2*L; // N*S2, always odd
    localparam int CW  = $clog2(WINDOW + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_MEAN, S_S1SQ, S_NS2, S_ROOT, S_STD, S_DONE
    } t_state;

    t_state r_state;

    // window state
    logic [CW-1:0]              r_count;
    logic signed [SW-1:0]       r_sum;
    logic [S2W-1:0]             r_sq2;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SAMPLE_W-1:0] r_min;

    // shift-add multiplier
    logic [PW-1:0] r_mcand;
    logic [MW-1:0] r_mplier;
    logic [PW-1:0] r_prod;

    // square root
    logic [PW-1:0] r_num;
    logic [PW-1:0] r_res;
    logic [PW-1:0] r_bit;

    // divider request and finished fields
    logic                       r_div_start;
    logic [MW-1:0]              r_div_arg;
    logic [SAMPLE_W-1:0]        r_mean;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_div_stat     div_stat;
    logic [MW-1:0] div_quot;
    logic [L-1:0]  div_rem;

    logic                       s_accept;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic [SAMPLE_W-1:0]        n_mag;
    logic [MW-1:0]              n_sum_mag;
    logic                       n_sum_neg;
    logic [MW-1:0]              n_mean_mag;
    logic [MW-1:0]              n_mean;
    logic [STD_W-1:0]           n_std;
    logic [PW-1:0]              n_rb;
    logic                       n_out_free;
    logic                       n_load;
    logic                       n_div_start;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign n_sample  = signed'(s_axis_tdata);
    assign n_mag     = n_sample[SAMPLE_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
    assign n_sum_neg = r_sum[SW-1];
    assign n_sum_mag = n_sum_neg ? MW'(~r_sum + 1'b1) : MW'(r_sum);

    // floor for negative sums: round the magnitude up
    assign n_mean_mag = div_quot + MW'(n_sum_neg && (div_rem != '0));
    assign n_mean     = n_sum_neg ? (~n_mean_mag + 1'b1) : n_mean_mag;

    // std clamp, kept as a guard
    assign n_std = (div_quot > MW'(STD_MAX)) ? STD_MAX : div_quot[STD_W-1:0];

    assign n_rb       = r_res + r_bit;
    assign n_out_free = !r_out_valid || m_axis_tready;
    assign n_load     = (r_state == S_DONE) && n_out_free;

    // divider kicks off after the last square and after the root
    assign n_div_start = ((r_state == S_SQ) && (r_mplier == '0)
                          && (r_count == CW'(WINDOW)))
                      || ((r_state == S_ROOT) && (r_bit == '0));

    wmsm_div #(
        .WINDOW (WINDOW),
        .DW     (MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_arg),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // sequencer, window state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq2       <= '0;
            r_max       <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            r_min       <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= n_div_start;
            r_out_valid <= n_load || (r_out_valid && !m_axis_tready);

            unique case (r_state) inside
                S_IDLE: begin
                    if (s_accept) begin
                        r_count  <= r_count + 1'b1;
                        r_sum    <= r_sum + SW'(n_sample);
                        if (n_sample > r_max) begin
                            r_max <= n_sample;
                        end
                        if (n_sample < r_min) begin
                            r_min <= n_sample;
                        end
                        // square accumulates onto the running sum of squares
                        r_prod   <= PW'(r_sq2);
                        r_mcand  <= PW'(n_mag);
                        r_mplier <= MW'(n_mag);
                        r_state  <= S_SQ;
                    end
                end

                S_SQ, S_S1SQ, S_NS2: begin
                    if (r_mplier != '0) begin
                        if (r_mplier[0]) begin
                            r_prod <= r_prod + r_mcand;
                        end
                        r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                        r_mplier <= {1'b0, r_mplier[MW-1:1]};
                    end else if (r_state == S_SQ) begin
                        r_sq2 <= r_prod[S2W-1:0];
                        if (r_count == CW'(WINDOW)) begin
                            r_div_arg <= n_sum_mag;
                            r_state   <= S_MEAN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_state == S_S1SQ) begin
                        // S1*S1 done, now N*S2
                        r_num    <= r_prod;
                        r_prod   <= '0;
                        r_mcand  <= PW'(r_sq2);
                        r_mplier <= MW'(WINDOW);
                        r_state  <= S_NS2;
                    end else begin
                        r_num   <= (r_prod >= r_num) ? (r_prod - r_num) : '0;
                        r_res   <= '0;
                        r_bit   <= PW'(1) << (PW - 1);
                        r_state <= S_ROOT;
                    end
                end

                S_MEAN: begin
                    if (div_stat.done) begin
                        r_mean   <= n_mean[SAMPLE_W-1:0];
                        r_prod   <= '0;
                        r_mcand  <= PW'(n_sum_mag);
                        r_mplier <= n_sum_mag;
                        r_state  <= S_S1SQ;
                    end
                end

                S_ROOT: begin
                    if (r_bit != '0) begin
                        if (r_num >= n_rb) begin
                            r_num <= r_num - n_rb;
                            r_res <= {1'b0, r_res[PW-1:1]} + r_bit;
                        end else begin
                            r_res <= {1'b0, r_res[PW-1:1]};
                        end
                        r_bit <= {2'b00, r_bit[PW-1:2]};
                    end else begin
                        r_div_arg <= r_res[MW-1:0];
                        r_state   <= S_STD;
                    end
                end

                S_STD: begin
                    if (div_stat.done) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // hand over the result, then start a fresh window;
                    // the divider stays idle so its quotient still holds
                    if (n_out_free) begin
                        r_out_data <= {1'b0, r_min, r_max, n_std, r_mean};
                        r_count    <= '0;
                        r_sum      <= '0;
                        r_sq2      <= '0;
                        r_max      <= {1'b1, {(SAMPLE_W-1){1'b0}}};
                        r_min      <= {1'b0, {(SAMPLE_W-1){1'b1}}};
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    `WMSM_ASSERT_NOW(a_div_owner, div_stat.done, (r_state == S_MEAN || r_state == S_STD))
    `WMSM_ASSERT_NOW(a_div_no_accept, div_stat.busy, !s_axis_tready)
    `WMSM_ASSERT_NEXT(a_load_result, n_load, m_axis_tvalid && (r_count == '0))
    `WMSM_ASSERT_NOW(a_count_range, s_axis_tready, r_count < CW'(WINDOW))

endmodule

// ----- tb/sv/tb_window_mean_std_min_max.sv -----
// ---------------------------------------------------------------------------
// tb_window_mean_std_min_max
// Self-checking bench for the windowed mean / std / max / min block.
// ---------------------------------------------------------------------------
// Samples are streamed in with random gaps. Each accepted sample also goes
// into a scoreboard that keeps its own window sums and predicts the result
// transfer at each window end. Results are taken with random back-pressure,
// including one long hold-off that fills the block and stalls the input.
// Every result is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_window_mean_std_min_max import wmsm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN        = WINDOW_DEF;
    localparam int N_ITEMS    = 1550;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_OFF   = 2500;
    localparam int TAIL       = 300;

    // Expected window result
    typedef struct {
        logic signed [SAMPLE_W-1:0] mean;
        logic [STD_W-1:0]           stdv;
        logic signed [SAMPLE_W-1:0] maxv;
        logic signed [SAMPLE_W-1:0] minv;
    } t_window_stats;

    // Window statistics predictor and result checker
    class wmsm_scoreboard;
        int unsigned                 n_seen;
        longint                      sum;
        longint unsigned             sq_sum;
        logic signed [SAMPLE_W-1:0]  hi;
        logic signed [SAMPLE_W-1:0]  lo;
        t_window_stats               stats_q[$];
        int unsigned                 errors;
        int unsigned                 results_checked;

        function new();
            errors = 0;
            results_checked = 0;
            clear_window();
        endfunction

        function void clear_window();
            n_seen = 0;
            sum    = 0;
            sq_sum = 0;
            hi     = 16'sh8000;
            lo     = 16'sh7FFF;
        endfunction

        // Digit-by-digit integer square root, result below 2^32
        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        // Accepted sample: update window, predict result at window end
        function void note_sample(logic [SAMPLE_W-1:0] raw);
            logic signed [SAMPLE_W-1:0] s;
            longint                     sv;
            longint                     q;
            longint unsigned            var_num;
            longint unsigned            mag_sq;
            longint unsigned            sd;
            t_window_stats              st;
            s  = raw;
            sv = s;
            sum    += sv;
            sq_sum += longint'(sv * sv);
            if (s > hi) hi = s;
            if (s < lo) lo = s;
            n_seen++;
            if (n_seen < WIN)
                return;
            // floor division toward minus infinity
            q = sum / WIN;
            if (sum < 0 && q * WIN != sum)
                q = q - 1;
            mag_sq  = (sum < 0) ? longint'(-sum) * longint'(-sum) : sum * sum;
            var_num = longint'(WIN) * sq_sum;
            var_num = (var_num >= mag_sq) ? var_num - mag_sq : 0;
            sd = int_sqrt(var_num) / WIN;
            if (sd > STD_MAX)
                sd = 64'(STD_MAX);
            st.mean = q[SAMPLE_W-1:0];
            st.stdv = sd[STD_W-1:0];
            st.maxv = hi;
            st.minv = lo;
            stats_q.push_back(st);
            clear_window();
        endfunction

        // Accepted result transfer: compare with oldest prediction
        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_window_stats st;
            logic signed [SAMPLE_W-1:0] mean_a;
            logic [STD_W-1:0]           std_a;
            logic signed [SAMPLE_W-1:0] max_a;
            logic signed [SAMPLE_W-1:0] min_a;
            mean_a = d[15:0];
            std_a  = d[30:16];
            max_a  = d[46:31];
            min_a  = d[62:47];
            results_checked++;
            if (stats_q.size() == 0) begin
                $error("result transfer with no window pending: tdata=%h", d);
                errors++;
                return;
            end
            st = stats_q.pop_front();
            if (mean_a !== st.mean) begin
                $error("window_mean: expected %0d, got %0d", st.mean, mean_a);
                errors++;
            end
            if (std_a !== st.stdv) begin
                $error("window_std: expected %0d, got %0d", st.stdv, std_a);
                errors++;
            end
            if (max_a !== st.maxv) begin
                $error("window_max: expected %0d, got %0d", st.maxv, max_a);
                errors++;
            end
            if (min_a !== st.minv) begin
                $error("window_min: expected %0d, got %0d", st.minv, min_a);
                errors++;
            end
            if (d[63] !== 1'b0) begin
                $error("tdata pad bit: expected 0, got %b", d[63]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return stats_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;   // [15:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [15:0] window_mean, [30:16] window_std, [46:31] window_max,
    // [62:47] window_min, [63] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    wmsm_scoreboard sb;
    bit             steady;      // no random gaps on either side while set
    bit             held_off;
    int unsigned    idle_cycles;

    window_mean_std_min_max #(
        .WINDOW(WIN)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady)  return 0;
        if (r < 55)  return 0;
        if (r < 85)  return $urandom_range(1, 3);
        if (r < 96)  return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // One sample transfer, entered and left at a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random sample for one window, shaped by pattern
    function automatic logic [SAMPLE_W-1:0] pick_sample(int pattern,
                                                        logic [SAMPLE_W-1:0] base);
        case (pattern) inside
            0, 1, 2, 3: begin
                return SAMPLE_W'($urandom);
            end
            4: begin
                return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
            end
            5: begin
                return base;
            end
            6: begin
                return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            7: begin
                return base + SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
            end
            default: begin
                return SAMPLE_W'($signed($urandom_range(0, 512)) - 256);
            end
        endcase
    endfunction

    // Monitors: note accepted samples, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_sample(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result receiver with random back-pressure and one long hold-off
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        held_off      = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held_off && sb.results_checked >= 10) begin
                gap      = HOLD_OFF;
                held_off = 1'b1;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Reset, stimulus and end of run
    initial begin
        int                  sent;
        int                  pattern;
        logic [SAMPLE_W-1:0] base;
        sb            = new();
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: alternating extremes give the largest std
        for (int i = 0; i < WIN; i++)
            send_sample(i[0] ? 16'h7FFF : 16'h8000);
        sent = WIN;

        // Random windows with varied shapes
        while (sent < N_ITEMS) begin
            pattern = $urandom_range(0, 8);
            base    = SAMPLE_W'($urandom);
            steady  = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < WIN; i++)
                send_sample(pick_sample(pattern, base));
            sent += WIN;
        end
        steady        = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/wmsm_pkg.sv
rtl/core/wmsm_div.sv
rtl/core/window_mean_std_min_max.sv
tb/sv/tb_window_mean_std_min_max.sv
